// ----- src/svga_pkg.sv -----
// Shared constants and arithmetic helpers for the state vector gate engine.
`timescale 1ns / 1ps
`default_nettype none
package svga_pkg;
	localparam int QUBIT_COUNT = 10;
	localparam int ADDR_W = QUBIT_COUNT;
	localparam int DEPTH = 1 << QUBIT_COUNT;
	localparam int NUM_REGS = 8;

	localparam logic [1:0] ACT_INIT = 2'd0;
	localparam logic [1:0] ACT_GATE = 2'd1;
	localparam logic [1:0] ACT_CGATE = 2'd2;
	localparam logic [1:0] ACT_READ = 2'd3;

	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	// Round an exact Q5.28 component to Q2.14 (half up) and saturate.
	function automatic logic signed [15:0] round_q14(input logic signed [32:0] v);
		logic signed [33:0] biased;
		logic signed [19:0] q;
		begin
			biased = 34'(v) + 34'sd8192;
			q = 20'(biased >>> 14);
			if (q > 20'sd32767) round_q14 = 16'sh7fff;
			else if (q < -20'sd32768) round_q14 = 16'sh8000;
			else round_q14 = q[15:0];
		end
	endfunction

	function automatic logic signed [15:0] add_sat(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [16:0] s;
		begin
			s = 17'(a) + 17'(b);
			if (s > 17'sd32767) add_sat = 16'sh7fff;
			else if (s < -17'sd32768) add_sat = 16'sh8000;
			else add_sat = s[15:0];
		end
	endfunction
endpackage
`default_nettype wire

// ----- src/state_vector_gate_apply_top.sv -----
// Gate engine top level: amplitude memory, sweep sequencer and pair datapath.
`timescale 1ns / 1ps
`default_nettype none
// Holds 2^QUBIT_COUNT complex Q2.14 amplitudes in one memory with one read and
// one write port. A gate request sweeps every amplitude pair; the read port
// fetches the low and then the high entry of a pair, and the multiply pipeline
// is drained before the response is given. An init request, and reset itself,
// rewrite the memory one entry a cycle; no request is accepted during that
// pass. A read request returns the stored entry, and a request with a bad
// qubit number is answered at once.
// One request is handled at a time and each gives one response.
module state_vector_gate_apply_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// action[1:0], target_qubit[5:2], control_qubit[9:6], amp_index[19:10]
	input wire logic [23:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// amp_re[15:0], amp_im[31:16]
	output logic [31:0] m_tdata,
	// status[0]
	output logic [0:0] m_tuser,
	input wire logic cfg_wen,
	input wire logic [3:0] cfg_idx,
	input wire logic [15:0] cfg_wdata
);
	import svga_pkg::*;

	localparam logic [2:0] ST_CLR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_GATE = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_READ = 3'd4;

	logic [2:0] state_q;
	logic signed [15:0] cfg_q [NUM_REGS];

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;
	logic mem_we, mem_re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [31:0] wdata;

	logic [ADDR_W-1:0] clr_q, p_q, tbit_q, cbit_q;
	logic ctrl_q, ph_q, resp_q;
	logic out_valid_q, out_status_q;
	logic [15:0] out_re_q, out_im_q;

	logic [1:0] in_action;
	logic [3:0] in_target, in_control;
	logic accept, bad_q;

	logic [ADDR_W-1:0] lowmask, lo_addr, hi_addr;
	logic iss_lo_q, iss_hi_q, iss_skip_q, skip_q1;
	logic [ADDR_W-1:0] iss_addr_q, addr_q1;
	logic [31:0] lo_q;

	logic v2, v3, v4, v5;
	logic skip_s2, skip_s3;
	logic [ADDR_W-1:0] a_s2, a_s3, a_s4, a_s5;
	logic [31:0] olo_s2, ohi_s2, olo_s3, ohi_s3, hi_s4, hi_s5;
	logic [31:0] lo_s4;
	logic signed [31:0] pa_s2 [4], pb_s2 [4], pc_s2 [4], pd_s2 [4];
	logic signed [15:0] re_s3 [4], im_s3 [4];
	logic signed [15:0] m_re [4], m_im [4], b_re [4], b_im [4];

	assign in_action = s_tdata[1:0];
	assign in_target = s_tdata[5:2];
	assign in_control = s_tdata[9:6];
	assign s_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		bad_q = 1'b0;
		if (in_action == ACT_GATE || in_action == ACT_CGATE)
			bad_q = (32'(in_target) >= QUBIT_COUNT);
		if (in_action == ACT_CGATE)
			bad_q = bad_q || (32'(in_control) >= QUBIT_COUNT) || (in_control == in_target);
	end

	// Pair address: insert a zero at the target bit position of the pair count.
	assign lowmask = tbit_q - ADDR_W'(1);
	assign lo_addr = ((p_q & ~lowmask) << 1) | (p_q & lowmask);
	assign hi_addr = lo_addr | tbit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_REGS; k++)
				cfg_q[k] <= (k == 0 || k == 6) ? ONE_Q14 : 16'sd0;
		end else if (cfg_wen && (32'(cfg_idx) < NUM_REGS)) begin
			cfg_q[cfg_idx[2:0]] <= cfg_wdata;
		end
	end

	always_comb begin
		mem_re = 1'b0;
		raddr = ADDR_W'(s_tdata[19:10]);
		if (state_q == ST_GATE) begin
			mem_re = 1'b1;
			raddr = ph_q ? hi_addr : lo_addr;
		end else if (accept && in_action == ACT_READ) begin
			mem_re = 1'b1;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		waddr = clr_q;
		wdata = '0;
		if (state_q == ST_CLR) begin
			mem_we = 1'b1;
			wdata = (clr_q == '0) ? {16'd0, ONE_Q14} : '0;
		end else if (v4) begin
			mem_we = 1'b1;
			waddr = a_s4;
			wdata = lo_s4;
		end else if (v5) begin
			mem_we = 1'b1;
			waddr = a_s5;
			wdata = hi_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			p_q <= '0;
			ph_q <= 1'b0;
			resp_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_re_q <= '0;
			out_im_q <= '0;
			out_status_q <= 1'b0;
			tbit_q <= '0;
			cbit_q <= '0;
			ctrl_q <= 1'b0;
			iss_lo_q <= 1'b0;
			iss_hi_q <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			iss_lo_q <= (state_q == ST_GATE) && !ph_q;
			iss_hi_q <= (state_q == ST_GATE) && ph_q;
			v2 <= iss_hi_q;
			v3 <= v2;
			v4 <= v3;
			v5 <= v4;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
						if (resp_q) begin
							out_valid_q <= 1'b1;
							out_re_q <= '0;
							out_im_q <= '0;
							out_status_q <= 1'b0;
						end
						resp_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (bad_q) begin
							out_valid_q <= 1'b1;
							out_re_q <= '0;
							out_im_q <= '0;
							out_status_q <= 1'b1;
						end else begin
							case (in_action)
								ACT_INIT: begin
									state_q <= ST_CLR;
									clr_q <= '0;
									resp_q <= 1'b1;
								end
								ACT_READ: state_q <= ST_READ;
								default: begin
									state_q <= ST_GATE;
									p_q <= '0;
									ph_q <= 1'b0;
									tbit_q <= ADDR_W'(1) << in_target;
									cbit_q <= ADDR_W'(1) << in_control;
									ctrl_q <= (in_action == ACT_CGATE);
								end
							endcase
						end
					end
				end
				ST_GATE: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						p_q <= p_q + ADDR_W'(1);
						if (p_q == ADDR_W'(DEPTH / 2 - 1)) state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!(iss_lo_q || iss_hi_q || v2 || v3 || v4 || v5)) begin
						state_q <= ST_IDLE;
						out_valid_q <= 1'b1;
						out_re_q <= '0;
						out_im_q <= '0;
						out_status_q <= 1'b0;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
					out_valid_q <= 1'b1;
					out_re_q <= rdata_q[15:0];
					out_im_q <= rdata_q[31:16];
					out_status_q <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Pair datapath: operands, products, rounded components, row sums.
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			m_re[j] = cfg_q[2 * j];
			m_im[j] = cfg_q[2 * j + 1];
			b_re[j] = (j % 2 == 0) ? $signed(lo_q[15:0]) : $signed(rdata_q[15:0]);
			b_im[j] = (j % 2 == 0) ? $signed(lo_q[31:16]) : $signed(rdata_q[31:16]);
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_GATE) && !ph_q) begin
			iss_addr_q <= lo_addr;
			iss_skip_q <= ctrl_q && ((lo_addr & cbit_q) == '0);
		end
		if (iss_lo_q) begin
			lo_q <= rdata_q;
			addr_q1 <= iss_addr_q;
			skip_q1 <= iss_skip_q;
		end
		for (int j = 0; j < 4; j++) begin
			pa_s2[j] <= m_re[j] * b_re[j];
			pb_s2[j] <= m_im[j] * b_im[j];
			pc_s2[j] <= m_im[j] * b_re[j];
			pd_s2[j] <= m_re[j] * b_im[j];
			re_s3[j] <= round_q14(33'(pa_s2[j]) - 33'(pb_s2[j]));
			im_s3[j] <= round_q14(33'(pc_s2[j]) + 33'(pd_s2[j]));
		end
		a_s2 <= addr_q1;
		skip_s2 <= skip_q1;
		olo_s2 <= lo_q;
		ohi_s2 <= rdata_q;
		a_s3 <= a_s2;
		skip_s3 <= skip_s2;
		olo_s3 <= olo_s2;
		ohi_s3 <= ohi_s2;
		a_s4 <= a_s3;
		if (skip_s3) begin
			lo_s4 <= olo_s3;
			hi_s4 <= ohi_s3;
		end else begin
			lo_s4 <= {add_sat(im_s3[0], im_s3[1]), add_sat(re_s3[0], re_s3[1])};
			hi_s4 <= {add_sat(im_s3[2], im_s3[3]), add_sat(re_s3[2], re_s3[3])};
		end
		a_s5 <= a_s4 | tbit_q;
		hi_s5 <= hi_s4;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_im_q, out_re_q};
	assign m_tuser = out_status_q;
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the state vector gate engine top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import svga_pkg::*;

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic status;
	} amp_resp_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [23:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_wen;
	logic [3:0] cfg_idx;
	logic [15:0] cfg_wdata;

	state_vector_gate_apply_top uut (.*);

	logic signed [15:0] gate_mat [NUM_REGS];
	logic [31:0] amp_mem [DEPTH];
	logic [23:0] req_queue [$];
	amp_resp_t resp_queue [$];
	int send_idle_pct;
	int recv_idle_pct;
	int fails = 0;
	longint cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic signed [15:0] sat16(input longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// Half-up rounding: arithmetic shift floors toward minus infinity.
	function automatic logic signed [15:0] rnd14(input longint v);
		return sat16((v + 8192) >>> 14);
	endfunction

	function automatic logic [31:0] mac_row(input int r, input logic [31:0] lo,
		input logic [31:0] hi);
		longint ar, ai, br, bi, cr, ci, dr, di;
		logic signed [15:0] p0r, p0i, p1r, p1i;
		ar = gate_mat[4*r]; ai = gate_mat[4*r+1];
		cr = gate_mat[4*r+2]; ci = gate_mat[4*r+3];
		br = $signed(lo[15:0]); bi = $signed(lo[31:16]);
		dr = $signed(hi[15:0]); di = $signed(hi[31:16]);
		p0r = rnd14(ar*br - ai*bi);
		p0i = rnd14(ai*br + ar*bi);
		p1r = rnd14(cr*dr - ci*di);
		p1i = rnd14(ci*dr + cr*di);
		return {sat16(longint'(p0i) + p1i), sat16(longint'(p0r) + p1r)};
	endfunction

	function automatic void reset_amps();
		for (int k = 0; k < DEPTH; k++) amp_mem[k] = '0;
		amp_mem[0] = {16'h0, ONE_Q14};
	endfunction

	function automatic amp_resp_t predict_amp(input logic [23:0] d);
		amp_resp_t res;
		logic [1:0] act;
		int t, c;
		logic [31:0] lo, hi;
		act = d[1:0]; t = d[5:2]; c = d[9:6];
		res = '0;
		if (act == ACT_INIT) reset_amps();
		else if (act == ACT_READ) begin
			res.re = amp_mem[d[10 +: ADDR_W]][15:0];
			res.im = amp_mem[d[10 +: ADDR_W]][31:16];
		end else if (t >= QUBIT_COUNT) res.status = 1'b1;
		else if (act == ACT_CGATE && (c >= QUBIT_COUNT || c == t)) res.status = 1'b1;
		else begin
			for (int k = 0; k < DEPTH; k++) begin
				if (k[t]) continue;
				if (act == ACT_CGATE && !k[c]) continue;
				lo = amp_mem[k];
				hi = amp_mem[k | (1 << t)];
				amp_mem[k] = mac_row(0, lo, hi);
				amp_mem[k | (1 << t)] = mac_row(1, lo, hi);
			end
		end
		return res;
	endfunction

	function automatic logic [23:0] mk_req(input logic [1:0] act, input int t,
		input int c, input int idx);
		return {4'h0, idx[9:0], c[3:0], t[3:0], act};
	endfunction

	// Driver: one pending request presented at a time, random sender gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				resp_queue.push_back(predict_amp(s_tdata));
				void'(req_queue.pop_front());
			end
			if ((!s_tvalid || s_tready) ) begin
				if (s_tvalid && s_tready ? req_queue.size() > 0 : req_queue.size() > 0)
					if ($urandom_range(99) >= send_idle_pct) begin
						s_tvalid <= 1'b1;
						s_tdata <= req_queue[0];
					end else s_tvalid <= 1'b0;
				else s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_tvalid && m_tready) begin
				if (resp_queue.size() == 0) begin
					$error("response with nothing expected");
					fails++;
				end else begin
					amp_resp_t e;
					e = resp_queue.pop_front();
					if (m_tdata[15:0] !== e.re) begin
						$error("amp_re expected %0d got %0d", e.re, $signed(m_tdata[15:0]));
						fails++;
					end
					if (m_tdata[31:16] !== e.im) begin
						$error("amp_im expected %0d got %0d", e.im, $signed(m_tdata[31:16]));
						fails++;
					end
					if (m_tuser[0] !== e.status) begin
						$error("status expected %0d got %0d", e.status, m_tuser[0]);
						fails++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd6000000) begin
			$display("FAIL state_vector_gate_apply_top");
			$finish;
		end
	end

	task automatic write_reg(input int idx, input logic [15:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx[3:0];
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx < NUM_REGS) gate_mat[idx] = val;
	endtask

	task automatic drain();
		wait (req_queue.size() == 0 && resp_queue.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// Mostly reads, with gates and controlled gates mixed in; an init now and then keeps values alive.
	task automatic push_random(input int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 5) req_queue.push_back(mk_req(ACT_INIT, $urandom, $urandom, $urandom));
			else if (r < 25)
				req_queue.push_back(mk_req(ACT_GATE, $urandom_range(r < 23 ? 9 : 15),
					$urandom, $urandom));
			else if (r < 45)
				req_queue.push_back(mk_req(ACT_CGATE, $urandom_range(r < 43 ? 9 : 15),
					$urandom_range(r < 42 ? 9 : 15), $urandom));
			else req_queue.push_back(mk_req(ACT_READ, $urandom, $urandom,
				$urandom_range(1023)));
		end
	endtask

	task automatic random_matrix();
		for (int k = 0; k < NUM_REGS; k++)
			write_reg(k, $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 23170)
				- 11585));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		send_idle_pct = 16;
		recv_idle_pct = 46;
		for (int k = 0; k < NUM_REGS; k++) gate_mat[k] = '0;
		gate_mat[0] = ONE_Q14;
		gate_mat[6] = ONE_Q14;
		reset_amps();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// Hadamard-like gate with 1/sqrt2 = 11585.
		write_reg(0, 16'sd11585); write_reg(1, 16'sd0); write_reg(2, 16'sd11585);
		write_reg(3, 16'sd0); write_reg(4, 16'sd11585); write_reg(5, 16'sd0);
		write_reg(6, -16'sd11585); write_reg(7, 16'sd0);
		write_reg(9, 16'h1234);
		req_queue.push_back(mk_req(ACT_READ, 0, 0, 0));
		req_queue.push_back(mk_req(ACT_GATE, 0, 15, 0));
		req_queue.push_back(mk_req(ACT_GATE, 9, 0, 0));
		req_queue.push_back(mk_req(ACT_CGATE, 1, 0, 0));
		req_queue.push_back(mk_req(ACT_CGATE, 3, 9, 0));
		req_queue.push_back(mk_req(ACT_READ, 15, 15, 1023));
		req_queue.push_back(mk_req(ACT_READ, 0, 0, 1));
		req_queue.push_back(mk_req(ACT_READ, 0, 0, 513));
		req_queue.push_back(mk_req(ACT_GATE, 10, 0, 0));
		req_queue.push_back(mk_req(ACT_GATE, 15, 0, 0));
		req_queue.push_back(mk_req(ACT_CGATE, 2, 2, 0));
		req_queue.push_back(mk_req(ACT_CGATE, 2, 10, 0));
		req_queue.push_back(mk_req(ACT_CGATE, 12, 1, 0));
		req_queue.push_back(mk_req(ACT_INIT, 15, 15, 1023));
		req_queue.push_back(mk_req(ACT_READ, 0, 0, 0));
		drain();
		// Extreme matrix drives the saturation paths.
		for (int k = 0; k < NUM_REGS; k++) write_reg(k, k[0] ? 16'sh8000 : 16'sh7fff);
		req_queue.push_back(mk_req(ACT_GATE, 0, 0, 0));
		req_queue.push_back(mk_req(ACT_GATE, 0, 0, 0));
		req_queue.push_back(mk_req(ACT_READ, 0, 0, 0));
		req_queue.push_back(mk_req(ACT_READ, 0, 0, 1));
		drain();
		for (int k = 0; k < NUM_REGS; k++) write_reg(k, k[0] ? 16'sh7fff : 16'sh8000);
		req_queue.push_back(mk_req(ACT_GATE, 1, 0, 0));
		req_queue.push_back(mk_req(ACT_READ, 0, 0, 2));
		req_queue.push_back(mk_req(ACT_READ, 0, 0, 0));
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			if (ph == 2) begin send_idle_pct = 46; recv_idle_pct = 16; end
			if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
			random_matrix();
			push_random(95);
		end
		drain();
		if (fails == 0) $display("PASS state_vector_gate_apply_top");
		else $display("FAIL state_vector_gate_apply_top");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
src/svga_pkg.sv
src/state_vector_gate_apply_top.sv
dv/tb_top.sv
